### src/psc_pkg.sv
// Package for the pressure sensor conditioner.
// Holds field widths, register codes, reset values, the queue item type and the
// millivolt-to-pressure conversion. No dependencies.
package psc_pkg;

    // Field widths
    localparam int MV_W       = 12;
    localparam int THR_W      = 16;
    localparam int SAMPLE_W   = 13;
    localparam int PRESS_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default window length of the moving average
    localparam int WINDOW_LEN_DEF = 4;

    // Depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_THR = 2'd2;

    // Register reset values
    localparam logic [MV_W-1:0]  LOW_LIMIT_RST  = 12'd200;
    localparam logic [MV_W-1:0]  HIGH_LIMIT_RST = 12'd2820;
    localparam logic [THR_W-1:0] REPORT_THR_RST = 16'd10;

    // Conversion constants, in thirds of a centibar
    localparam logic [SAMPLE_W-1:0] PRESS_OFFSET = 13'd600;
    localparam logic [SAMPLE_W-1:0] PRESS_MAX    = 13'd4800;
    localparam int                  PRESS_MAX_INT = 4800;

    // Saturation value of the failure count
    localparam logic [THR_W-1:0] COUNT_MAX = 16'hFFFF;

    // One classified request handed from front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                push;
        logic                fault;
        logic [THR_W-1:0]    err_count;
        logic                pulse;
    } psc_item_t;

    // Convert millivolts to thirds of a centibar: 2*mV - 600, clamped to 0..4800
    function automatic logic [SAMPLE_W-1:0] to_thirds(input logic [MV_W-1:0] mv);
        logic [SAMPLE_W-1:0] twice;
        logic [SAMPLE_W-1:0] diff;
        twice = {mv, 1'b0};
        diff  = twice - PRESS_OFFSET;
        if (twice <= PRESS_OFFSET)
        begin
            return '0;
        end
        else if (diff > PRESS_MAX)
        begin
            return PRESS_MAX;
        end
        else
        begin
            return diff;
        end
    endfunction

endpackage

### src/pressure_sensor_conditioner.sv
// A sample whose fault flag ends clear is divided by the one-bit-per-cycle divider in
// the back over SUM_W quotient bits (SUM_W = 15 at WINDOW_LEN 4); a sample held on
// fault skips the divider. The queue takes new samples while the back is busy.
// Two requests queue behind the divider while a result waits at the output.
// Reset (rst_n, asynchronous, active low) restores register defaults and clears the
// window, sums, fault flag, failure count and held pressure at once.
module pressure_sensor_conditioner
    import psc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MV_W-1:0]       voltage_mv,
    input  logic                  sensor_present,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PRESS_W-1:0]    pressure_cbar,
    output logic                  fault,
    output logic [THR_W-1:0]      error_count,
    output logic                  report_pulse,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    psc_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    psc_item_t back_item;
    logic      back_valid;
    logic      back_ready;

    // Classify samples
    psc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .voltage_mv     (voltage_mv),
        .sensor_present (sensor_present),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (front_valid),
        .item_ready     (front_ready),
        .item           (front_item)
    );

    // Buffer requests between the two parts
    psc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_item  (back_item)
    );

    // Filter and deliver results
    psc_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (back_valid),
        .item_ready    (back_ready),
        .item          (back_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pressure_cbar (pressure_cbar),
        .fault         (fault),
        .error_count   (error_count),
        .report_pulse  (report_pulse)
    );

endmodule

### src/psc_front.sv
// Front part of the pressure sensor conditioner: configuration registers,
// limit check, fault flag and failure count. Classifies each request for the back.
// Depends on psc_pkg.
module psc_front
    import psc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Sample channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MV_W-1:0]       voltage_mv,
    input  logic                  sensor_present,
    // Configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Classified request toward the queue
    output logic                  item_valid,
    input  logic                  item_ready,
    output psc_item_t             item
);

    logic [MV_W-1:0]  low_limit_reg;
    logic [MV_W-1:0]  high_limit_reg;
    logic [THR_W-1:0] report_thr_reg;
    logic             fault_reg;
    logic             fault_next;
    logic [THR_W-1:0] count_reg;
    logic [THR_W-1:0] count_next;
    logic             pulse;
    logic             in_range;
    logic             accept;

    assign cfg_ready  = 1'b1;
    assign in_ready   = item_ready;
    assign item_valid = in_valid;
    assign accept     = in_valid && item_ready;

    // Check the window and update fault state
    always_comb
    begin
        in_range   = (voltage_mv >= low_limit_reg) && (voltage_mv <= high_limit_reg);
        fault_next = fault_reg;
        count_next = count_reg;
        pulse      = 1'b0;
        if (sensor_present)
        begin
            if (!in_range)
            begin
                fault_next = 1'b1;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                    pulse      = (count_next == report_thr_reg);
                end
            end
            else
            begin
                fault_next = 1'b0;
                count_next = '0;
            end
        end
    end

    // Build the request for the back
    always_comb
    begin
        item.sample    = (sensor_present && in_range) ? to_thirds(voltage_mv) : '0;
        item.push      = !fault_next;
        item.fault     = fault_next;
        item.err_count = count_next;
        item.pulse     = pulse;
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= LOW_LIMIT_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
            report_thr_reg <= REPORT_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT:  low_limit_reg  <= cfg_data[MV_W-1:0];
                CFG_HIGH_LIMIT: high_limit_reg <= cfg_data[MV_W-1:0];
                CFG_REPORT_THR: report_thr_reg <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Advance fault state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            fault_reg <= fault_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/psc_queue.sv
// Short request queue between front and back of the pressure sensor conditioner.
// Flop-based FIFO of psc_item_t entries. Depends on psc_pkg.
module psc_queue
    import psc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  psc_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output psc_item_t rd_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    psc_item_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Store incoming requests
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/psc_back.sv
// Back part of the pressure sensor conditioner: moving-average window,
// bit-serial division by 3*fill and the output register. Depends on psc_pkg.
module psc_back
    import psc_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Request from the queue
    input  logic               item_valid,
    output logic               item_ready,
    input  psc_item_t          item,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PRESS_W-1:0] pressure_cbar,
    output logic               fault,
    output logic [THR_W-1:0]   error_count,
    output logic               report_pulse
);

    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = $clog2(PRESS_MAX_INT * WINDOW_LEN + 1);
    localparam int DIV_W  = $clog2(3 * WINDOW_LEN + 1);
    localparam int ITER_W = $clog2(SUM_W);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

    state_t              state_reg;
    psc_item_t           item_reg;
    logic [SAMPLE_W-1:0] window_reg [WINDOW_LEN];
    logic [SLOT_W-1:0]   slot_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [DIV_W-1:0]    fill_ext;
    logic [DIV_W-1:0]    divisor_next;
    logic [DIV_W-1:0]    divisor_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W:0]      rem_shift;
    logic                rem_ge;
    logic [DIV_W-1:0]    rem_next;
    logic [SUM_W-1:0]    dividend_reg;
    logic [SUM_W-1:0]    dividend_next;
    logic [ITER_W-1:0]   iter_reg;
    logic [PRESS_W-1:0]  held_reg;
    logic                pop;
    logic                load_out;

    assign item_ready = (state_reg == ST_IDLE);
    assign pop        = item_valid && item_ready;
    assign load_out   = (state_reg == ST_FIN) && (!out_valid || out_ready);

    // Window update for the popped request
    always_comb
    begin
        fill_next    = (fill_reg < FILL_W'(WINDOW_LEN)) ? fill_reg + 1'b1 : fill_reg;
        sum_next     = sum_reg - SUM_W'(window_reg[slot_reg]) + SUM_W'(item.sample);
        fill_ext     = DIV_W'(fill_next);
        divisor_next = (fill_ext << 1) + fill_ext;
    end

    // One restoring division step
    always_comb
    begin
        rem_shift     = {rem_reg, dividend_reg[SUM_W-1]};
        rem_ge        = (rem_shift >= {1'b0, divisor_reg});
        rem_next      = rem_ge ? DIV_W'(rem_shift - {1'b0, divisor_reg}) : DIV_W'(rem_shift);
        dividend_next = {dividend_reg[SUM_W-2:0], rem_ge};
    end

    // Hold window contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (pop && item.push)
        begin
            window_reg[slot_reg] <= item.sample;
        end
    end

    // Sequence the back: pop, divide, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            held_reg      <= '0;
            iter_reg      <= '0;
            out_valid     <= 1'b0;
            item_reg      <= '0;
            divisor_reg   <= '0;
            rem_reg       <= '0;
            dividend_reg  <= '0;
            pressure_cbar <= '0;
            fault         <= 1'b0;
            error_count   <= '0;
            report_pulse  <= 1'b0;
        end
        else
        begin
            // Drop the result once taken
            if (out_valid && out_ready && !load_out)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        item_reg <= item;
                        if (item.push)
                        begin
                            fill_reg     <= fill_next;
                            sum_reg      <= sum_next;
                            slot_reg     <= (slot_reg == SLOT_W'(WINDOW_LEN - 1)) ?
                                            '0 : slot_reg + 1'b1;
                            dividend_reg <= sum_next;
                            divisor_reg  <= divisor_next;
                            rem_reg      <= '0;
                            iter_reg     <= '0;
                            state_reg    <= ST_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_DIV:
                begin
                    rem_reg      <= rem_next;
                    dividend_reg <= dividend_next;
                    iter_reg     <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(SUM_W - 1))
                    begin
                        held_reg  <= dividend_next[PRESS_W-1:0];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (load_out)
                    begin
                        pressure_cbar <= held_reg;
                        fault         <= item_reg.fault;
                        error_count   <= item_reg.err_count;
                        report_pulse  <= item_reg.pulse;
                        out_valid     <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // Division never runs against a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (divisor_reg != '0))
        else $error("psc_back: division with zero divisor");

    // Fill count never passes the window length
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("psc_back: fill count beyond window");

    // The remainder stays below the divisor at every division step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < divisor_reg))
        else $error("psc_back: remainder not below divisor");

    // A new result is only loaded from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_FIN))
        else $error("psc_back: result loaded outside finish state");
`endif

endmodule

### test/tb.sv
// Self-checking testbench for pressure_sensor_conditioner.
// Drives samples and register writes over valid/ready, predicts every reading in a
// scoreboard class and compares field by field. Depends on src/psc_pkg.sv and the RTL.
module tb;
    import psc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AVG_LEN = WINDOW_LEN_DEF;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_REQUESTS = 100;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One predicted reading
    typedef struct packed {
        logic [PRESS_W-1:0] pressure;
        logic               fault;
        logic [THR_W-1:0]   count;
        logic               pulse;
    } reading_t;

    // Predicts conditioner readings and checks them in order
    class pressure_scoreboard;
        logic [MV_W-1:0]     low_mv;
        logic [MV_W-1:0]     high_mv;
        logic [THR_W-1:0]    thr;
        logic [SAMPLE_W-1:0] window [AVG_LEN];
        int unsigned         slot;
        int unsigned         filled;
        int unsigned         sum;
        logic                faulted;
        logic [THR_W-1:0]    fails;
        logic [PRESS_W-1:0]  held;
        reading_t            expected_readings [$];
        int                  mismatches;
        int                  checked;
        int                  pulses;

        function new();
            low_mv = LOW_LIMIT_RST;
            high_mv = HIGH_LIMIT_RST;
            thr = REPORT_THR_RST;
            foreach (window[i])
                window[i] = '0;
            slot = 0;
            filled = 0;
            sum = 0;
            faulted = 1'b0;
            fails = '0;
            held = '0;
            mismatches = 0;
            checked = 0;
            pulses = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LOW_LIMIT:  low_mv = data[MV_W-1:0];
                CFG_HIGH_LIMIT: high_mv = data[MV_W-1:0];
                CFG_REPORT_THR: thr = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // 2*mV - 600 in thirds of a centibar, clamped to the sensor span
        function int unsigned mv_to_thirds(int unsigned mv);
            int unsigned twice;
            twice = 2 * mv;
            if (twice <= int'(PRESS_OFFSET))
                return 0;
            twice = twice - int'(PRESS_OFFSET);
            return (twice > PRESS_MAX_INT) ? PRESS_MAX_INT : twice;
        endfunction

        // Advance the filter state for one accepted request
        function void accept_sample(logic [MV_W-1:0] mv, logic present);
            reading_t    r;
            int unsigned value;
            int unsigned pos;
            value = 0;
            r.pulse = 1'b0;
            if (present)
            begin
                if (mv < low_mv || mv > high_mv)
                begin
                    faulted = 1'b1;
                    if (fails != COUNT_MAX)
                    begin
                        fails = fails + 1'b1;
                        if (fails == thr)
                            r.pulse = 1'b1;
                    end
                end
                else
                begin
                    faulted = 1'b0;
                    fails = '0;
                    value = mv_to_thirds(mv);
                end
            end
            // push into the moving average unless faulted
            if (!faulted)
            begin
                pos = slot;
                if (filled < AVG_LEN)
                    filled++;
                sum = sum - window[pos] + value;
                window[pos] = SAMPLE_W'(value);
                slot = (pos + 1) % AVG_LEN;
                held = PRESS_W'(sum / (3 * filled));
            end
            r.pressure = held;
            r.fault = faulted;
            r.count = fails;
            expected_readings.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one accepted reading against the oldest prediction
        task check_reading(logic [PRESS_W-1:0] pressure, logic flt, logic [THR_W-1:0] count,
                           logic pulse);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                report($sformatf("reading p=%0d f=%0d c=%0d r=%0d with nothing pending",
                                 pressure, flt, count, pulse));
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            if (pulse)
                pulses++;
            if (pressure !== want.pressure)
                report($sformatf("reading %0d pressure_cbar got %0d want %0d",
                                 checked, pressure, want.pressure));
            if (flt !== want.fault)
                report($sformatf("reading %0d fault got %0d want %0d",
                                 checked, flt, want.fault));
            if (count !== want.count)
                report($sformatf("reading %0d error_count got %0d want %0d",
                                 checked, count, want.count));
            if (pulse !== want.pulse)
                report($sformatf("reading %0d report_pulse got %0d want %0d",
                                 checked, pulse, want.pulse));
        endtask

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MV_W-1:0]       voltage_mv = '0;
    logic                  sensor_present = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [PRESS_W-1:0]    pressure_cbar;
    logic                  fault;
    logic [THR_W-1:0]      error_count;
    logic                  report_pulse;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pressure_scoreboard sb;
    logic idle_on = 1'b0;
    int   requests_sent = 0;
    int   settings_used = 0;

    pressure_sensor_conditioner #(.WINDOW_LEN(AVG_LEN)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .voltage_mv     (voltage_mv),
        .sensor_present (sensor_present),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pressure_cbar  (pressure_cbar),
        .fault          (fault),
        .error_count    (error_count),
        .report_pulse   (report_pulse),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the reading side in random bursts while idling is on
    always
    begin
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        out_ready <= 1'b1;
    end

    // Check every accepted reading
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reading(pressure_cbar, fault, error_count, report_pulse);
    end

    // Offer one request; return at the falling edge after it is taken, valid still high
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic present);
        in_valid <= 1'b1;
        voltage_mv <= mv;
        sensor_present <= present;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_sample(mv, present);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Wait until every predicted reading has come back, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_limits(input logic [CFG_DATA_W-1:0] low,
                                  input logic [CFG_DATA_W-1:0] high,
                                  input logic [CFG_DATA_W-1:0] thr);
        write_reg(CFG_LOW_LIMIT, low);
        write_reg(CFG_HIGH_LIMIT, high);
        write_reg(CFG_REPORT_THR, thr);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Voltage outside the current window, or any voltage if the window is full span
    function automatic logic [MV_W-1:0] pick_fault_voltage();
        int unsigned lo;
        int unsigned hi;
        lo = sb.low_mv;
        hi = sb.high_mv;
        if (lo > 0 && (hi == 4095 || $urandom_range(0, 1) == 0))
            return MV_W'($urandom_range(0, lo - 1));
        if (hi < 4095)
            return MV_W'($urandom_range(hi + 1, 4095));
        return MV_W'($urandom_range(0, 4095));
    endfunction

    // Mostly in-window voltages, with window edges, faults and free values mixed in
    function automatic logic [MV_W-1:0] pick_voltage();
        int unsigned lo;
        int unsigned hi;
        int unsigned roll;
        lo = sb.low_mv;
        hi = sb.high_mv;
        roll = $urandom_range(0, 99);
        if (roll < 55 && lo <= hi)
            return MV_W'($urandom_range(lo, hi));
        if (roll < 68)
        begin
            case ($urandom_range(0, 3))
                0: return MV_W'(lo);
                1: return MV_W'(hi);
                2: return MV_W'((lo > 0) ? lo - 1 : lo);
                default: return MV_W'((hi < 4095) ? hi + 1 : hi);
            endcase
        end
        if (roll < 82)
            return pick_fault_voltage();
        return MV_W'($urandom_range(0, 4095));
    endfunction

    // Pick a random register setting, extremes included
    task automatic random_setting();
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        logic [CFG_DATA_W-1:0] thr;
        int unsigned           base;
        case ($urandom_range(0, 5))
            0:
            begin
                low = LOW_LIMIT_RST;
                high = HIGH_LIMIT_RST;
            end
            1:
            begin
                low = CFG_DATA_W'($urandom_range(0, 600));
                high = CFG_DATA_W'($urandom_range(2400, 3300));
            end
            2:
            begin
                low = 16'h0000;
                high = 16'hFFFF;
            end
            3:
            begin
                low = CFG_DATA_W'($urandom_range(2000, 4095));
                high = CFG_DATA_W'($urandom_range(0, 1999));
            end
            4:
            begin
                base = $urandom_range(0, 3800);
                low = CFG_DATA_W'(base);
                high = CFG_DATA_W'(base + $urandom_range(0, 200));
            end
            default:
            begin
                low = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
                high = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            end
        endcase
        // stray upper bits on the limits are ignored by the 12-bit registers
        if ($urandom_range(0, 3) == 0)
        begin
            low[15:12] = 4'($urandom_range(0, 15));
            high[15:12] = 4'($urandom_range(0, 15));
        end
        case ($urandom_range(0, 9))
            0: thr = 16'd0;
            1: thr = CFG_DATA_W'($urandom_range(0, 16'hFFFF));
            default: thr = CFG_DATA_W'($urandom_range(1, 12));
        endcase
        program_limits(low, high, thr);
    endtask

    // Run of failures and absent-sensor requests, at least as long as the report threshold
    task automatic fault_burst();
        int len;
        len = sb.thr + $urandom_range(0, 2);
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                send_sample(MV_W'($urandom_range(0, 4095)), 1'b0);
            else
                send_sample(pick_fault_voltage(), 1'b1);
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: window edges, clamp points and channel not configured, reset limits
        send_sample(12'd0, 1'b1);
        send_sample(12'd199, 1'b1);
        send_sample(12'd2821, 1'b1);
        send_sample(12'd4095, 1'b0);
        send_sample(12'd200, 1'b1);
        send_sample(12'd300, 1'b1);
        send_sample(12'd301, 1'b1);
        send_sample(12'd2820, 1'b1);
        send_sample(12'd1234, 1'b0);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd1650, 1'b1);
        send_sample(12'd3300, 1'b1);
        drain();

        // Report pulse at a threshold of three, then no pulse past it
        write_reg(CFG_UNUSED, 16'hA5A5);
        program_limits(16'd200, 16'd2820, 16'd3);
        repeat (4) send_sample(12'd100, 1'b1);
        send_sample(12'd0, 1'b0);
        drain();

        // Zero threshold never pulses
        program_limits(16'd200, 16'd2820, 16'd0);
        repeat (2) send_sample(12'd4000, 1'b1);
        send_sample(12'd1000, 1'b1);
        drain();

        // Full-span window: top voltage passes and clamps
        program_limits(16'd0, 16'd4095, 16'd1);
        send_sample(12'd4095, 1'b1);
        send_sample(12'd0, 1'b1);
        drain();

        // Crossed limits fault every configured sample
        program_limits(16'd3000, 16'd100, 16'd1);
        send_sample(12'd1500, 1'b1);
        send_sample(12'd50, 1'b1);
        send_sample(12'd0, 1'b0);
        drain();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setting();
            idle_on = (phase < RANDOM_PHASES - 3) && ($urandom_range(0, 3) != 0);
            sent = requests_sent;
            while (requests_sent - sent < PHASE_REQUESTS)
            begin
                if (phase == 4 && requests_sent - sent == PHASE_REQUESTS / 2)
                    drain();
                if (sb.thr != 0 && sb.thr <= 20 && $urandom_range(0, 11) == 0)
                    fault_burst();
                else
                    send_sample(pick_voltage(), $urandom_range(0, 9) != 0);
                if (idle_on && $urandom_range(0, 7) == 0)
                    hold_off($urandom_range(1, 12));
            end
            drain();
        end
        idle_on = 1'b0;

        $display("covered %0d requests over %0d register settings", requests_sent, settings_used);
        $display("checked %0d readings, %0d report pulses, %0d mismatches",
                 sb.checked, sb.pulses, sb.mismatches);
        if (sb.mismatches == 0)
            $display("pressure_sensor_conditioner regression: pass");
        else
            $display("pressure_sensor_conditioner regression: fail");
        $finish;
    end

    // Bound the run
    initial
    begin
        #8ms;
        $display("timeout with %0d readings outstanding", sb.pending());
        $display("pressure_sensor_conditioner regression: fail");
        $finish;
    end

endmodule
